FILE: src/ambient_backlight_dimmer_macros.svh
// Assertion macros for the ambient backlight dimmer.
// No dependencies; included by the top level, which carries the assertions.
`ifndef AMBIENT_BACKLIGHT_DIMMER_MACROS_SVH
`define AMBIENT_BACKLIGHT_DIMMER_MACROS_SVH

// Same-cycle implication under reset.
`define ABD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define ABD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/abd_pkg.sv
// Shared types and constants of the ambient backlight dimmer.
// No dependencies; used by abd_regs, the top level and the testbench.
package abd_pkg;

	localparam int unsigned PADDR_W = 5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_DARK_TH   = 3'd0;
	localparam logic [2:0] REG_DIM_TH    = 3'd1;
	localparam logic [2:0] REG_DWELL     = 3'd2;
	localparam logic [2:0] REG_WAKE_DW   = 3'd3;
	localparam logic [2:0] REG_OFF_LVL   = 3'd4;
	localparam logic [2:0] REG_LOW_LVL   = 3'd5;
	localparam logic [2:0] REG_NORM_LVL  = 3'd6;
	localparam logic [2:0] REG_RAMP      = 3'd7;

	localparam logic [9:0]  DARK_TH_RST  = 10'd100;
	localparam logic [9:0]  DIM_TH_RST   = 10'd400;
	localparam logic [31:0] DWELL_RST    = 32'd5000;
	localparam logic [31:0] WAKE_DW_RST  = 32'd1000;
	localparam logic [7:0]  OFF_LVL_RST  = 8'd0;
	localparam logic [7:0]  LOW_LVL_RST  = 8'd64;
	localparam logic [7:0]  NORM_LVL_RST = 8'd255;
	localparam logic [15:0] RAMP_RST     = 16'd1000;

	localparam logic [9:0] WAKE_PRESSURE_MIN = 10'd5;
	localparam logic [2:0] DIV_LAST          = 3'd7;

	typedef struct packed {
		logic [9:0]  dark_threshold;
		logic [9:0]  dim_threshold;
		logic [31:0] dwell_ms;
		logic [31:0] wake_dwell_ms;
		logic [7:0]  off_level;
		logic [7:0]  low_level;
		logic [7:0]  normal_level;
		logic [15:0] ramp_ms;
	} cfg_t;

	typedef enum logic [1:0] {
		CLS_DARK,
		CLS_DIM,
		CLS_BRIGHT
	} cls_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WK_RUN,
		ST_WK_CHK,
		ST_LT_RUN,
		ST_LT_CHK,
		ST_PICK,
		ST_RAMP,
		ST_MUL,
		ST_DIV,
		ST_ADJ,
		ST_EMIT
	} state_t;

endpackage

FILE: src/abd_regs.sv
// Configuration register file of the ambient backlight dimmer, APB-style slave.
// Depends on abd_pkg for the register indexes, reset values and cfg_t.
module abd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output abd_pkg::cfg_t               cfg
);

	abd_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign idx    = paddr[abd_pkg::PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= abd_pkg::DARK_TH_RST;
			cfg_q.dim_threshold  <= abd_pkg::DIM_TH_RST;
			cfg_q.dwell_ms       <= abd_pkg::DWELL_RST;
			cfg_q.wake_dwell_ms  <= abd_pkg::WAKE_DW_RST;
			cfg_q.off_level      <= abd_pkg::OFF_LVL_RST;
			cfg_q.low_level      <= abd_pkg::LOW_LVL_RST;
			cfg_q.normal_level   <= abd_pkg::NORM_LVL_RST;
			cfg_q.ramp_ms        <= abd_pkg::RAMP_RST;
		end else if (wr_en) begin
			case (idx)
				abd_pkg::REG_DARK_TH:  cfg_q.dark_threshold <= pwdata[9:0];
				abd_pkg::REG_DIM_TH:   cfg_q.dim_threshold  <= pwdata[9:0];
				abd_pkg::REG_DWELL:    cfg_q.dwell_ms       <= pwdata;
				abd_pkg::REG_WAKE_DW:  cfg_q.wake_dwell_ms  <= pwdata;
				abd_pkg::REG_OFF_LVL:  cfg_q.off_level      <= pwdata[7:0];
				abd_pkg::REG_LOW_LVL:  cfg_q.low_level      <= pwdata[7:0];
				abd_pkg::REG_NORM_LVL: cfg_q.normal_level   <= pwdata[7:0];
				abd_pkg::REG_RAMP:     cfg_q.ramp_ms        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			abd_pkg::REG_DARK_TH:  prdata = {22'd0, cfg_q.dark_threshold};
			abd_pkg::REG_DIM_TH:   prdata = {22'd0, cfg_q.dim_threshold};
			abd_pkg::REG_DWELL:    prdata = cfg_q.dwell_ms;
			abd_pkg::REG_WAKE_DW:  prdata = cfg_q.wake_dwell_ms;
			abd_pkg::REG_OFF_LVL:  prdata = {24'd0, cfg_q.off_level};
			abd_pkg::REG_LOW_LVL:  prdata = {24'd0, cfg_q.low_level};
			abd_pkg::REG_NORM_LVL: prdata = {24'd0, cfg_q.normal_level};
			abd_pkg::REG_RAMP:     prdata = {16'd0, cfg_q.ramp_ms};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/abd_subcmp.sv
// Shared subtract-and-compare unit of the ambient backlight dimmer.
// Depends on nothing; the sequencer in the top level drives its operands.
module abd_subcmp (
	input  logic [31:0] opa,
	input  logic [31:0] opb,
	input  logic [31:0] lim,
	output logic [31:0] diff,
	output logic        ge,
	output logic        nb
);

	logic [32:0] full;

	// diff wraps modulo 2^32; nb is high when opa >= opb
	assign full = {1'b0, opa} - {1'b0, opb};
	assign diff = full[31:0];
	assign nb   = !full[32];
	assign ge   = diff >= lim;

endmodule

FILE: src/ambient_backlight_dimmer.sv
// Ambient backlight dimmer: top level with the update sequencer and datapath.
// Depends on abd_pkg, abd_regs, abd_subcmp and ambient_backlight_dimmer_macros.svh.
//
// Each accepted update item (timestamp, light sample, proximity, touch pressure,
// alarm) runs through a small sequencer that drives one shared 32-bit subtract
// and compare unit: two steps for the wake dwell timer (one when not woken), two
// for the dwell timer of the light class (dark, dim or bright), one to pick the
// target level, one to check the ramp time, one 8x16 multiply and eight restoring
// divide steps for the linear ramp, one step for rounding, and one to hand the
// result to the output register; the multiply, divide and rounding steps are
// skipped when no ramp is running. upd_stall stays high from acceptance until the
// result is loaded, and the next item can be taken in the cycle after. A result
// waits in the output register until res_stall is low; the next item may be taken
// meanwhile and is held in its final step while the previous result is still
// unclaimed. Configuration must be written through the APB-style port only while
// no item is in flight; the block does not enforce this. pready is always high.
// Reset gives a fresh part: timers idle, ramp, current and target levels at 255.
`include "ambient_backlight_dimmer_macros.svh"

module ambient_backlight_dimmer (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// update item
	input  logic                        upd_valid,
	output logic                        upd_stall,
	input  logic [31:0]                 now_ms,
	input  logic [9:0]                  light_sample,
	input  logic                        proximity_near,
	input  logic [9:0]                  touch_pressure,
	input  logic                        alarm_active,
	// result item
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [7:0]                  backlight_level,
	output logic                        level_written,
	output logic [7:0]                  target_level_out
);

	abd_pkg::cfg_t   cfg;
	abd_pkg::state_t state_q, state_nx;

	// latched item
	logic [31:0]   now_q;
	logic          woken_q;
	abd_pkg::cls_t cls_q;
	abd_pkg::cls_t cls_in;
	logic          woken_in;

	// dwell timers: wake plus one per light class
	logic [31:0] wk_start_q, wk_latest_q;
	logic [31:0] tmr_start_q  [3];
	logic [31:0] tmr_latest_q [3];
	logic        wk_done_q, cls_done_q;

	// ramp state
	logic [7:0]  ramp_lvl_q, cur_lvl_q, tgt_lvl_q;
	logic [31:0] ramp_time_q;
	logic        written_q;

	// ramp arithmetic scratch
	logic        up_q;
	logic [7:0]  span_q;
	logic [15:0] elap_q;
	logic [15:0] rem_q;
	logic [7:0]  dvd_q;
	logic [7:0]  quo_q;
	logic [2:0]  div_cnt_q;

	// result register
	logic        res_valid_q;
	logic [7:0]  res_lvl_q, res_tgt_q;
	logic        res_wr_q;

	// shared unit
	logic [31:0] alu_a, alu_b, alu_lim, alu_diff;
	logic        alu_ge, alu_nb;

	// helpers
	logic        wk_fresh, lt_fresh;
	logic [31:0] sel_start, sel_latest;
	logic [16:0] div_shift;
	logic        slot_free;
	logic        dwell0, wake0;
	logic        dark_done, dim_done, bright_done, wake_done;
	logic        pick_any;
	logic [7:0]  pick_lvl;
	logic [23:0] prod;
	logic [7:0]  quo_adj;
	logic [7:0]  lvl_new;

	abd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abd_subcmp u_alu (
		.opa  (alu_a),
		.opb  (alu_b),
		.lim  (alu_lim),
		.diff (alu_diff),
		.ge   (alu_ge),
		.nb   (alu_nb)
	);

	assign upd_stall        = (state_q != abd_pkg::ST_IDLE);
	assign res_valid        = res_valid_q;
	assign backlight_level  = res_lvl_q;
	assign level_written    = res_wr_q;
	assign target_level_out = res_tgt_q;

	// Classify the incoming sample; a dark test wins over an inverted dim threshold.
	always_comb begin
		woken_in = proximity_near || alarm_active ||
			(touch_pressure > abd_pkg::WAKE_PRESSURE_MIN);
		if (light_sample <= cfg.dark_threshold) begin
			cls_in = abd_pkg::CLS_DARK;
		end else if (light_sample <= cfg.dim_threshold) begin
			cls_in = abd_pkg::CLS_DIM;
		end else begin
			cls_in = abd_pkg::CLS_BRIGHT;
		end
	end

	// A start of zero means the timer is idle. While woken every light timer is
	// cleared first, so the current class timer restarts at now.
	assign wk_fresh   = (wk_start_q == 32'd0);
	assign sel_start  = woken_q ? 32'd0 : tmr_start_q[cls_q];
	assign sel_latest = woken_q ? 32'd0 : tmr_latest_q[cls_q];
	assign lt_fresh   = (sel_start == 32'd0);
	assign div_shift  = {rem_q, dvd_q[7]};
	assign slot_free  = !res_valid_q || !res_stall;

	// Target choice; an idle timer counts as done only when its wait is zero.
	always_comb begin
		dwell0      = (cfg.dwell_ms == 32'd0);
		wake0       = (cfg.wake_dwell_ms == 32'd0);
		dark_done   = dwell0 || (cls_q == abd_pkg::CLS_DARK && cls_done_q);
		dim_done    = dwell0 || (cls_q == abd_pkg::CLS_DIM && cls_done_q);
		bright_done = dwell0 || (cls_q == abd_pkg::CLS_BRIGHT && cls_done_q);
		wake_done   = woken_q ? wk_done_q : wake0;
		pick_any    = 1'b1;
		if (dark_done) begin
			pick_lvl = cfg.off_level;
		end else if (dim_done || wake_done) begin
			pick_lvl = cfg.low_level;
		end else if (bright_done) begin
			pick_lvl = cfg.normal_level;
		end else begin
			pick_lvl = tgt_lvl_q;
			pick_any = 1'b0;
		end
	end

	// Ramp arithmetic: product is below span * ramp_ms, so the quotient fits 8 bits.
	assign prod    = 24'(span_q) * 24'(elap_q);
	assign quo_adj = quo_q + {7'd0, (!up_q && rem_q != 16'd0)};
	assign lvl_new = up_q ? (ramp_lvl_q + quo_adj) : (ramp_lvl_q - quo_adj);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			abd_pkg::ST_IDLE:   if (upd_valid) state_nx = abd_pkg::ST_WK_RUN;
			abd_pkg::ST_WK_RUN: state_nx = woken_q ? abd_pkg::ST_WK_CHK : abd_pkg::ST_LT_RUN;
			abd_pkg::ST_WK_CHK: state_nx = abd_pkg::ST_LT_RUN;
			abd_pkg::ST_LT_RUN: state_nx = abd_pkg::ST_LT_CHK;
			abd_pkg::ST_LT_CHK: state_nx = abd_pkg::ST_PICK;
			abd_pkg::ST_PICK:   state_nx = abd_pkg::ST_RAMP;
			abd_pkg::ST_RAMP: begin
				if (cur_lvl_q == tgt_lvl_q || cfg.ramp_ms == 16'd0 || alu_ge) begin
					state_nx = abd_pkg::ST_EMIT;
				end else begin
					state_nx = abd_pkg::ST_MUL;
				end
			end
			abd_pkg::ST_MUL:    state_nx = abd_pkg::ST_DIV;
			abd_pkg::ST_DIV:    if (div_cnt_q == abd_pkg::DIV_LAST) state_nx = abd_pkg::ST_ADJ;
			abd_pkg::ST_ADJ:    state_nx = abd_pkg::ST_EMIT;
			abd_pkg::ST_EMIT:   if (slot_free) state_nx = abd_pkg::ST_IDLE;
			default:            state_nx = abd_pkg::ST_IDLE;
		endcase
	end

	// Operands of the shared unit for each step.
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		alu_lim = 32'd0;
		case (state_q)
			abd_pkg::ST_WK_RUN: begin
				alu_a   = wk_fresh ? now_q : wk_latest_q;
				alu_b   = wk_fresh ? now_q : wk_start_q;
				alu_lim = cfg.wake_dwell_ms;
			end
			abd_pkg::ST_WK_CHK: begin
				alu_a   = wk_latest_q;
				alu_b   = wk_start_q;
				alu_lim = cfg.wake_dwell_ms;
			end
			abd_pkg::ST_LT_RUN: begin
				alu_a   = lt_fresh ? now_q : sel_latest;
				alu_b   = lt_fresh ? now_q : sel_start;
				alu_lim = cfg.dwell_ms;
			end
			abd_pkg::ST_LT_CHK: begin
				alu_a   = tmr_latest_q[cls_q];
				alu_b   = tmr_start_q[cls_q];
				alu_lim = cfg.dwell_ms;
			end
			abd_pkg::ST_RAMP: begin
				alu_a   = now_q;
				alu_b   = ramp_time_q;
				alu_lim = {16'd0, cfg.ramp_ms};
			end
			abd_pkg::ST_DIV: begin
				alu_a   = {15'd0, div_shift};
				alu_b   = {16'd0, cfg.ramp_ms};
			end
			default: ;
		endcase
	end

	// Control and persistent state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abd_pkg::ST_IDLE;
			wk_start_q  <= 32'd0;
			wk_latest_q <= 32'd0;
			for (int i = 0; i < 3; i++) begin
				tmr_start_q[i]  <= 32'd0;
				tmr_latest_q[i] <= 32'd0;
			end
			ramp_lvl_q  <= abd_pkg::NORM_LVL_RST;
			cur_lvl_q   <= abd_pkg::NORM_LVL_RST;
			tgt_lvl_q   <= abd_pkg::NORM_LVL_RST;
			ramp_time_q <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// load a new result when the slot frees, else drop the claimed one
			if (state_q == abd_pkg::ST_EMIT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				abd_pkg::ST_WK_RUN: begin
					if (woken_q) begin
						// advance latest only while the dwell is not yet met
						wk_start_q  <= alu_b;
						wk_latest_q <= alu_ge ? alu_a : now_q;
					end else begin
						wk_start_q  <= 32'd0;
						wk_latest_q <= 32'd0;
					end
				end
				abd_pkg::ST_LT_RUN: begin
					for (int i = 0; i < 3; i++) begin
						if (2'(i) == cls_q) begin
							tmr_start_q[i]  <= alu_b;
							tmr_latest_q[i] <= alu_ge ? alu_a : now_q;
						end else begin
							tmr_start_q[i]  <= 32'd0;
							tmr_latest_q[i] <= 32'd0;
						end
					end
				end
				abd_pkg::ST_PICK: begin
					if (pick_any && pick_lvl != tgt_lvl_q) begin
						ramp_lvl_q  <= cur_lvl_q;
						tgt_lvl_q   <= pick_lvl;
						ramp_time_q <= now_q;
					end
				end
				abd_pkg::ST_RAMP: begin
					// jump to the target when ramp time is zero or already spent
					if (cur_lvl_q != tgt_lvl_q && (cfg.ramp_ms == 16'd0 || alu_ge)) begin
						cur_lvl_q <= tgt_lvl_q;
					end
				end
				abd_pkg::ST_ADJ: begin
					cur_lvl_q <= lvl_new;
				end
				default: ;
			endcase
		end
	end

	// Item payload and arithmetic scratch.
	always_ff @(posedge clk) begin
		case (state_q)
			abd_pkg::ST_IDLE: begin
				if (upd_valid) begin
					now_q   <= now_ms;
					woken_q <= woken_in;
					cls_q   <= cls_in;
				end
			end
			abd_pkg::ST_WK_CHK: wk_done_q  <= alu_ge;
			abd_pkg::ST_LT_CHK: cls_done_q <= alu_ge;
			abd_pkg::ST_RAMP: begin
				written_q <= (cur_lvl_q != tgt_lvl_q);
				elap_q    <= alu_diff[15:0];
				up_q      <= (ramp_lvl_q <= tgt_lvl_q);
				span_q    <= (ramp_lvl_q <= tgt_lvl_q) ? (tgt_lvl_q - ramp_lvl_q)
					: (ramp_lvl_q - tgt_lvl_q);
			end
			abd_pkg::ST_MUL: begin
				rem_q     <= prod[23:8];
				dvd_q     <= prod[7:0];
				quo_q     <= 8'd0;
				div_cnt_q <= 3'd0;
			end
			abd_pkg::ST_DIV: begin
				// one restoring step: subtract ramp_ms when it fits
				rem_q     <= alu_nb ? alu_diff[15:0] : div_shift[15:0];
				dvd_q     <= {dvd_q[6:0], 1'b0};
				quo_q     <= {quo_q[6:0], alu_nb};
				div_cnt_q <= div_cnt_q + 3'd1;
			end
			abd_pkg::ST_EMIT: begin
				if (slot_free) begin
					res_lvl_q <= cur_lvl_q;
					res_tgt_q <= tgt_lvl_q;
					res_wr_q  <= written_q;
				end
			end
			default: ;
		endcase
	end

	`ABD_ASSERT_NXT(a_accept_starts, clk, arst_n, upd_valid && !upd_stall, state_q == abd_pkg::ST_WK_RUN, "accepted item did not start the sequence")
	`ABD_ASSERT_IMP(a_div_rem, clk, arst_n, state_q == abd_pkg::ST_DIV, rem_q < cfg.ramp_ms, "divider remainder out of range")
	`ABD_ASSERT_IMP(a_quo_span, clk, arst_n, state_q == abd_pkg::ST_ADJ, quo_q <= span_q, "ramp step exceeds span")
	`ABD_ASSERT_IMP(a_idle_level, clk, arst_n, res_valid && !level_written, backlight_level == target_level_out, "level differs from target without a write")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the ambient backlight dimmer: update items in, level items out.
// Depends on abd_pkg and the ambient_backlight_dimmer top level; builds its own level predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any accepted item before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// long receiver hold-off that fills the block and backs up the sender
	localparam int HOLD_CYCLES = 300;
	// worst-case cycles from acceptance to a loaded result, with margin
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [31:0] now;
		logic [9:0]  light;
		logic        near;
		logic [9:0]  pressure;
		logic        alarm;
	} update_t;

	typedef struct packed {
		logic [7:0] level;
		logic       written;
		logic [7:0] target;
	} level_result_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] latest;
	} dwell_timer_t;

	// Tracks dwell timers and the ramp, and holds the levels still to come out.
	class backlight_tracker;
		logic [9:0]  dark_th, dim_th;
		logic [31:0] dwell, wake_dwell;
		logic [7:0]  off_lvl, low_lvl, norm_lvl;
		logic [15:0] ramp;
		dwell_timer_t dark_t, dim_t, bright_t, wake_t;
		logic [7:0]  ramp_from, level, target;
		logic [31:0] ramp_t0;
		level_result_t pending[$];
		int failures;

		function new();
			dark_th = abd_pkg::DARK_TH_RST;
			dim_th = abd_pkg::DIM_TH_RST;
			dwell = abd_pkg::DWELL_RST;
			wake_dwell = abd_pkg::WAKE_DW_RST;
			off_lvl = abd_pkg::OFF_LVL_RST;
			low_lvl = abd_pkg::LOW_LVL_RST;
			norm_lvl = abd_pkg::NORM_LVL_RST;
			ramp = abd_pkg::RAMP_RST;
			dark_t = '0;
			dim_t = '0;
			bright_t = '0;
			wake_t = '0;
			ramp_from = 8'd255;
			level = 8'd255;
			target = 8'd255;
			ramp_t0 = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				abd_pkg::REG_DARK_TH:  dark_th = value[9:0];
				abd_pkg::REG_DIM_TH:   dim_th = value[9:0];
				abd_pkg::REG_DWELL:    dwell = value;
				abd_pkg::REG_WAKE_DW:  wake_dwell = value;
				abd_pkg::REG_OFF_LVL:  off_lvl = value[7:0];
				abd_pkg::REG_LOW_LVL:  low_lvl = value[7:0];
				abd_pkg::REG_NORM_LVL: norm_lvl = value[7:0];
				abd_pkg::REG_RAMP:     ramp = value[15:0];
				default: ;
			endcase
		endfunction

		function dwell_timer_t timer_advance(dwell_timer_t t, logic [31:0] now,
				logic [31:0] lim);
			dwell_timer_t r;
			logic [31:0] d;
			r = t;
			if (r.start == 32'd0) begin
				r.start = now;
				r.latest = now;
			end
			d = r.latest - r.start;
			if (d < lim)
				r.latest = now;
			return r;
		endfunction

		function bit timer_done(dwell_timer_t t, logic [31:0] lim);
			logic [31:0] d;
			d = t.latest - t.start;
			return d >= lim;
		endfunction

		function void retarget(logic [7:0] lvl, logic [31:0] now);
			if (target != lvl) begin
				ramp_from = level;
				target = lvl;
				ramp_t0 = now;
			end
		endfunction

		function void note_update(update_t u);
			level_result_t r;
			logic [31:0] el32;
			logic [63:0] el, span, x, q, rm;
			logic [7:0] lvl;
			bit woken;
			woken = u.near || (u.pressure > abd_pkg::WAKE_PRESSURE_MIN) || u.alarm;
			// wake wipes every light timer; the class timer restarts below
			if (woken) begin
				wake_t = timer_advance(wake_t, u.now, wake_dwell);
				dark_t = '0;
				dim_t = '0;
				bright_t = '0;
			end else
				wake_t = '0;
			if (u.light <= dark_th) begin
				dark_t = timer_advance(dark_t, u.now, dwell);
				dim_t = '0;
				bright_t = '0;
			end else if (u.light <= dim_th) begin
				dim_t = timer_advance(dim_t, u.now, dwell);
				dark_t = '0;
				bright_t = '0;
			end else begin
				bright_t = timer_advance(bright_t, u.now, dwell);
				dark_t = '0;
				dim_t = '0;
			end
			if (timer_done(dark_t, dwell))
				retarget(off_lvl, u.now);
			else if (timer_done(dim_t, dwell) || timer_done(wake_t, wake_dwell))
				retarget(low_lvl, u.now);
			else if (timer_done(bright_t, dwell))
				retarget(norm_lvl, u.now);
			r.written = 1'b0;
			if (level != target) begin
				r.written = 1'b1;
				el32 = u.now - ramp_t0;
				el = {32'd0, el32};
				rm = {48'd0, ramp};
				if (ramp == 16'd0)
					lvl = target;
				else if (ramp_from <= target) begin
					// rising ramp truncates down
					span = {56'd0, 8'(target - ramp_from)};
					q = (span * el) / rm;
					if (q > span)
						q = span;
					lvl = ramp_from + q[7:0];
				end else begin
					// falling ramp rounds the step up so the level truncates down
					span = {56'd0, 8'(ramp_from - target)};
					x = span * el;
					q = x / rm;
					if (q * rm != x)
						q = q + 64'd1;
					if (q > span)
						q = span;
					lvl = ramp_from - q[7:0];
				end
				level = lvl;
			end
			r.level = level;
			r.target = target;
			pending.push_back(r);
		endfunction

		function void check_level(level_result_t got);
			level_result_t want;
			if (pending.size() == 0) begin
				$error("level item with no update outstanding: level %0d written %0d target %0d",
					got.level, got.written, got.target);
				failures++;
				return;
			end
			want = pending.pop_front();
			if (got.level !== want.level) begin
				$error("backlight_level: expected %0d, got %0d", want.level, got.level);
				failures++;
			end
			if (got.written !== want.written) begin
				$error("level_written: expected %0d, got %0d", want.written, got.written);
				failures++;
			end
			if (got.target !== want.target) begin
				$error("target_level_out: expected %0d, got %0d", want.target, got.target);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [abd_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic upd_valid, upd_stall;
	logic [31:0] now_ms;
	logic [9:0] light_sample;
	logic proximity_near;
	logic [9:0] touch_pressure;
	logic alarm_active;
	logic res_valid, res_stall;
	logic [7:0] backlight_level;
	logic level_written;
	logic [7:0] target_level_out;

	backlight_tracker tracker = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int item_no = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;
	logic [31:0] clock_ms = '0;

	ambient_backlight_dimmer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.upd_valid        (upd_valid),
		.upd_stall        (upd_stall),
		.now_ms           (now_ms),
		.light_sample     (light_sample),
		.proximity_near   (proximity_near),
		.touch_pressure   (touch_pressure),
		.alarm_active     (alarm_active),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.backlight_level  (backlight_level),
		.level_written    (level_written),
		.target_level_out (target_level_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	// Drive only at the falling edge so the block sees a settled stall.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else
				res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every accepted level item against the oldest prediction, and
	// watch for a hang: any accepted item on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles = 0;
		else begin
			if (res_valid && !res_stall)
				tracker.check_level('{backlight_level, level_written, target_level_out});
			if ((upd_valid && !upd_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("** ambient_backlight_dimmer: FAILED **");
					$finish;
				end
			end
		end
	end

	function automatic update_t mk(logic [31:0] now, logic [9:0] light, logic near,
			logic [9:0] pressure, logic alarm);
		update_t u;
		u.now = now;
		u.light = light;
		u.near = near;
		u.pressure = pressure;
		u.alarm = alarm;
		return u;
	endfunction

	// Pick the idle mix from the item count: sender-light first, then
	// receiver-light, then none; request the long hold-off once.
	task automatic pace();
		item_no++;
		if (item_no < 150) begin
			send_idle_pct = 11;
			recv_idle_pct = 86;
		end else if (item_no < 300) begin
			send_idle_pct = 86;
			recv_idle_pct = 11;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if (item_no == 300)
			hold_req = 1'b1;
	endtask

	// Offer one update item; hold it steady until the block takes it.
	task automatic send_update(update_t u);
		bit go;
		go = 1'b0;
		pace();
		while (!go) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct)
				upd_valid <= 1'b0;
			else
				go = 1'b1;
		end
		upd_valid <= 1'b1;
		now_ms <= u.now;
		light_sample <= u.light;
		proximity_near <= u.near;
		touch_pressure <= u.pressure;
		alarm_active <= u.alarm;
		do
			@(posedge clk);
		while (upd_stall);
		tracker.note_update(u);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait for every predicted level, then let the pipeline go quiet.
	task automatic settle(int extra);
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apply_settings(logic [9:0] dark, logic [9:0] dim, logic [31:0] dwell,
			logic [31:0] wake, logic [7:0] lvl_off, logic [7:0] lvl_low,
			logic [7:0] lvl_norm, logic [15:0] ramp);
		// withdraw the last offer so it is not taken a second time
		@(negedge clk);
		upd_valid <= 1'b0;
		settle(DRAIN_CYCLES);
		apb_write(abd_pkg::REG_DARK_TH, {22'd0, dark});
		apb_write(abd_pkg::REG_DIM_TH, {22'd0, dim});
		apb_write(abd_pkg::REG_DWELL, dwell);
		apb_write(abd_pkg::REG_WAKE_DW, wake);
		apb_write(abd_pkg::REG_OFF_LVL, {24'd0, lvl_off});
		apb_write(abd_pkg::REG_LOW_LVL, {24'd0, lvl_low});
		apb_write(abd_pkg::REG_NORM_LVL, {24'd0, lvl_norm});
		apb_write(abd_pkg::REG_RAMP, {16'd0, ramp});
	endtask

	// Draw a light sample inside the requested class under the current thresholds;
	// fall back to any value for an empty dim class, 1023 for an empty bright one.
	function automatic logic [9:0] pick_light(abd_pkg::cls_t c);
		int dk, dm, hi;
		dk = int'(tracker.dark_th);
		dm = int'(tracker.dim_th);
		hi = (dk > dm) ? dk : dm;
		case (c)
			abd_pkg::CLS_DARK: return 10'($urandom_range(dk, 0));
			abd_pkg::CLS_DIM: begin
				if (dm > dk)
					return 10'($urandom_range(dm, dk + 1));
				return 10'($urandom_range(1023, 0));
			end
			default: begin
				if (hi < 1023)
					return 10'($urandom_range(1023, hi + 1));
				return 10'd1023;
			end
		endcase
	endfunction

	// Mostly coherent scenes: a monotonic clock, light held in one class for
	// a while, wake episodes on and off. A few items are pure noise or jump
	// the clock anywhere, including back to zero.
	task automatic random_items(int step_max, int count);
		abd_pkg::cls_t scene;
		bit waking;
		update_t u;
		int k, r;
		scene = abd_pkg::CLS_BRIGHT;
		waking = 1'b0;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(11) == 0)
				scene = abd_pkg::cls_t'($urandom_range(2));
			if ($urandom_range(14) == 0)
				waking = !waking;
			r = $urandom_range(99);
			if (r < 3)
				clock_ms = $urandom();
			else if (r < 4)
				clock_ms = '0;
			else
				clock_ms = clock_ms + 32'($urandom_range(step_max, 0));
			u.now = clock_ms;
			if ($urandom_range(99) < 8) begin
				u.light = 10'($urandom());
				u.near = 1'($urandom());
				u.pressure = 10'($urandom());
				u.alarm = 1'($urandom());
			end else begin
				u.light = pick_light(scene);
				if (waking) begin
					u.near = 1'($urandom());
					u.alarm = 1'($urandom());
					u.pressure = 10'($urandom());
					case ($urandom_range(2))
						0: u.near = 1'b1;
						1: u.pressure = 10'($urandom_range(1023, 6));
						default: u.alarm = 1'b1;
					endcase
				end else begin
					u.near = 1'b0;
					u.alarm = 1'b0;
					u.pressure = 10'($urandom_range(5, 0));
				end
			end
			send_update(u);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		upd_valid = 1'b0;
		now_ms = '0;
		light_sample = '0;
		proximity_near = 1'b0;
		touch_pressure = '0;
		alarm_active = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under reset settings. A timer started at time zero
		// restarts next update; dark then pulls the target down.
		send_update(mk(32'd0, 10'd0, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'd1, 10'd0, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'd6000, 10'd0, 1'b0, 10'd0, 1'b0));
		// falling ramp midway, then class boundaries
		send_update(mk(32'd6500, 10'd1023, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'd7000, 10'd400, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'd7001, 10'd401, 1'b0, 10'd0, 1'b0));
		// pressure of exactly the threshold does not wake, one above does
		send_update(mk(32'd7002, 10'd101, 1'b0, 10'd5, 1'b0));
		send_update(mk(32'd7003, 10'd101, 1'b0, 10'd6, 1'b0));
		send_update(mk(32'd8100, 10'd101, 1'b0, 10'd1023, 1'b0));
		send_update(mk(32'd8200, 10'd101, 1'b1, 10'd0, 1'b0));
		send_update(mk(32'd8300, 10'd101, 1'b0, 10'd0, 1'b1));
		send_update(mk(32'd9000, 10'd1023, 1'b1, 10'd1023, 1'b1));
		// wake ends: bright restarts and eventually selects normal
		send_update(mk(32'd9001, 10'd1023, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'd15000, 10'd1023, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'hFFFF_FFFF, 10'd1023, 1'b0, 10'd0, 1'b0));
		// clock wraps past zero; ramp elapsed time wraps with it
		send_update(mk(32'h0000_0010, 10'd100, 1'b0, 10'd0, 1'b0));
		send_update(mk(32'h7FFF_FFFF, 10'd1023, 1'b1, 10'd1023, 1'b1));
		send_update(mk(32'h8000_0000, 10'd512, 1'b0, 10'h2AA, 1'b0));
		send_update(mk(32'hFFFF_FFF0, 10'h155, 1'b0, 10'h155, 1'b0));
		send_update(mk(32'd0, 10'd0, 1'b0, 10'd0, 1'b0));

		// Random phases over a spread of settings: short dwells so targets
		// move, zero dwells, inverted thresholds, extreme levels and ramps.
		apply_settings(10'd100, 10'd400, 32'd60, 32'd20, 8'd0, 8'd64, 8'd255, 16'd100);
		random_items(25, 90);
		apply_settings(10'd0, 10'd1023, 32'd0, 32'd0, 8'd255, 8'd0, 8'd128, 16'd1);
		random_items(10, 50);
		apply_settings(10'd600, 10'd200, 32'd40, 32'd80, 8'd10, 8'd200, 8'd30, 16'd65535);
		random_items(20, 60);
		apply_settings(10'd1023, 10'd0, 32'hFFFF_FFFF, 32'd30, 8'd0, 8'd17, 8'd255, 16'd0);
		random_items(15, 40);
		apply_settings(10'd300, 10'd700, 32'd200, 32'd50, 8'd5, 8'd100, 8'd250, 16'd500);
		random_items(60, 110);
		apply_settings(10'd50, 10'd900, 32'd100, 32'hFFFF_FFFF, 8'd255, 8'd128, 8'd0,
			16'd3000);
		random_items(40, 90);

		@(negedge clk);
		upd_valid <= 1'b0;
		settle(DRAIN_CYCLES);

		if (tracker.failures == 0 && tracker.pending.size() == 0)
			$display("** ambient_backlight_dimmer: PASSED **");
		else
			$display("** ambient_backlight_dimmer: FAILED **");
		$finish;
	end

endmodule
